FILE: hdl/membership_table_failure_detector_unit_assert.svh
// Assertion macros for the membership table failure detector.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef MEMBERSHIP_TABLE_FAILURE_DETECTOR_UNIT_ASSERT_SVH
`define MEMBERSHIP_TABLE_FAILURE_DETECTOR_UNIT_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next.
`define MTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MTFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mtfd_pkg.sv
// Shared types and constants for the membership table failure detector.
// No dependencies.
`default_nettype none
package mtfd_pkg;
	localparam int MaxNodes = 64;
	localparam int NodeW = 6;

	localparam logic [2:0] REQ_MERGE  = 3'd0;
	localparam logic [2:0] REQ_TICK   = 3'd1;
	localparam logic [2:0] REQ_ROUND  = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_DEPART = 3'd4;

	localparam logic [1:0] ST_ALIVE   = 2'd0;
	localparam logic [1:0] ST_SUSPECT = 2'd1;
	localparam logic [1:0] ST_DEAD    = 2'd2;

	localparam logic [2:0] CFG_SELF_ID  = 3'd0;
	localparam logic [2:0] CFG_SELF_GEN = 3'd1;
	localparam logic [2:0] CFG_SUSPECT  = 3'd2;
	localparam logic [2:0] CFG_DEAD     = 3'd3;

	localparam logic [31:0] HB_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {FSM_IDLE, FSM_EXEC, FSM_COLLECT} fsm_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              en;
		logic [2:0]        typ;
		logic [NodeW-1:0]  node;
		logic [31:0]       gen;
		logic [31:0]       hb;
		logic [1:0]        st;
		logic              force_req;
		logic [31:0]       clock_ms;
		logic [NodeW-1:0]  self_id;
		logic [31:0]       suspect_limit;
		logic [31:0]       dead_limit;
		logic              reload;
		logic [NodeW-1:0]  new_self;
		logic [31:0]       new_gen;
	} cell_cmd_t;

	// Record a cell presents.
	typedef struct packed {
		logic        valid;
		logic [31:0] gen;
		logic [31:0] hb;
		logic [1:0]  st;
	} cell_rec_t;
endpackage
`default_nettype wire

FILE: hdl/membership_table_failure_detector_unit.sv
// Membership table failure detector: a chain of 64 record cells under a small sequencer.
// Depends on mtfd_pkg, mtfd_cell and membership_table_failure_detector_unit_assert.svh.
//
// Each word passes through accept, an update step in which every cell updates its own
// record in parallel, and a collect step that selects the reported entry and counts alive
// peers into the output register. The collect step stretches for as long as an earlier
// result still waits unaccepted on the master side. A new word is taken once the
// sequencer is back in idle, which it reaches while the previous result may still wait
// on the master side.
// Configuration writes are always accepted; writing the own node number or
// generation clears the old own entry and loads a fresh one.
`default_nettype none
module membership_table_failure_detector_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// node_num[5:0], in_generation[37:6], in_heartbeat[69:38], in_status[71:70],
	// force_req[72], zero fill [79:73]
	input  wire logic [79:0]  s_tdata,
	// req_type[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_node[5:0], known[6], out_generation[38:7], out_heartbeat[70:39],
	// out_status[72:71], changed[73], alive_mask[137:74], peer_count[144:138],
	// zero fill [151:145]
	output logic [151:0]      m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import mtfd_pkg::*;

	fsm_t state_q, state_d;
	logic [NodeW-1:0] self_id_q;
	logic [31:0] self_gen_q, suspect_q, dead_q, clock_q;
	logic [2:0] typ_q;
	logic [NodeW-1:0] node_q;
	logic [31:0] gen_q, hb_q;
	logic [1:0] st_q;
	logic force_q;
	logic m_valid_q;
	logic [151:0] m_data_q;
	logic cfg_wr, in_acc, load_out;
	cell_cmd_t cmd;
	cell_rec_t recs [MaxNodes];
	logic chain [MaxNodes+1];
	logic [MaxNodes-1:0] alive_mask;
	logic [NodeW-1:0] rep;
	logic [6:0] peers;
	logic [1:0] st_in;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid;
	assign s_tready = (state_q == FSM_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign st_in = (s_tdata[71:70] == 2'd3) ? ST_DEAD : s_tdata[71:70];

	// Sequencer: next state and output load
	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		case (state_q)
			FSM_IDLE: if (in_acc) state_d = FSM_EXEC;
			FSM_EXEC: state_d = FSM_COLLECT;
			FSM_COLLECT: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	// Configuration registers and the millisecond clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= '0;
			self_gen_q <= 32'd1;
			suspect_q <= 32'd3000;
			dead_q <= 32'd10000;
			clock_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_SELF_ID:  self_id_q <= cfg_data[NodeW-1:0];
					CFG_SELF_GEN: self_gen_q <= cfg_data;
					CFG_SUSPECT:  suspect_q <= cfg_data;
					CFG_DEAD:     dead_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == FSM_EXEC && typ_q == REQ_TICK) clock_q <= clock_q + 32'd1;
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			typ_q <= s_tuser;
			node_q <= s_tdata[5:0];
			gen_q <= s_tdata[37:6];
			hb_q <= s_tdata[69:38];
			st_q <= st_in;
			force_q <= s_tdata[72];
		end
	end

	// Broadcast command to the cells
	always_comb begin
		cmd.en = (state_q == FSM_EXEC);
		cmd.typ = typ_q;
		cmd.node = node_q;
		cmd.gen = gen_q;
		cmd.hb = hb_q;
		cmd.st = st_q;
		cmd.force_req = force_q;
		cmd.clock_ms = clock_q;
		cmd.self_id = self_id_q;
		cmd.suspect_limit = suspect_q;
		cmd.dead_limit = dead_q;
		cmd.reload = cfg_wr && (cfg_index == CFG_SELF_ID || cfg_index == CFG_SELF_GEN);
		cmd.new_self = (cfg_index == CFG_SELF_ID) ? cfg_data[NodeW-1:0] : self_id_q;
		cmd.new_gen = (cfg_index == CFG_SELF_GEN) ? cfg_data : self_gen_q;
	end

	assign chain[0] = 1'b0;
	for (genvar i = 0; i < MaxNodes; i++) begin : g_cell
		mtfd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (NodeW'(i)),
			.cmd     (cmd),
			.chg_in  (chain[i]),
			.rec     (recs[i]),
			.chg_out (chain[i+1])
		);
		assign alive_mask[i] = recs[i].valid && (recs[i].st == ST_ALIVE);
	end

	// Select the reported entry and count alive peers
	always_comb begin
		rep = node_q;
		if (typ_q == REQ_TICK || typ_q == REQ_ROUND || typ_q == REQ_DEPART) rep = self_id_q;
		peers = 7'($countones(alive_mask)) - {6'd0, alive_mask[self_id_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (load_out) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {7'd0, peers, alive_mask, chain[MaxNodes],
				recs[rep].valid ? recs[rep].st : 2'd0,
				recs[rep].valid ? recs[rep].hb : 32'd0,
				recs[rep].valid ? recs[rep].gen : 32'd0,
				recs[rep].valid, rep};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

`include "membership_table_failure_detector_unit_assert.svh"

	`MTFD_ASSERT_NEXT(a_acc_exec, in_acc, state_q == FSM_EXEC, "accept not followed by update")
	`MTFD_ASSERT_NEXT(a_self_load, cfg_wr && cfg_index == CFG_SELF_ID,
		recs[self_id_q].valid, "own entry not loaded")
	`MTFD_ASSERT_NOW(a_peers, m_tvalid, m_tdata[144:138] <= 7'd63, "peer count too large")
endmodule
`default_nettype wire

FILE: hdl/mtfd_cell.sv
// One membership record cell: holds a node entry and applies broadcast commands.
// Depends on mtfd_pkg.
`default_nettype none
module mtfd_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [mtfd_pkg::NodeW-1:0] idx,
	input  wire mtfd_pkg::cell_cmd_t       cmd,
	input  wire logic                      chg_in,
	output mtfd_pkg::cell_rec_t            rec,
	output logic                           chg_out
);
	import mtfd_pkg::*;

	logic        valid_q, valid_d;
	logic [31:0] gen_q, gen_d;
	logic [31:0] hb_q, hb_d;
	logic [1:0]  st_q, st_d;
	logic [31:0] stamp_q, stamp_d;
	logic        chg_q, chg_d;
	logic        is_self, take;
	logic [31:0] age;
	logic [1:0]  st_age;

	// Work out the next record for the current command
	always_comb begin
		is_self = (idx == cmd.self_id);
		age = cmd.clock_ms - stamp_q;
		valid_d = valid_q;
		gen_d = gen_q;
		hb_d = hb_q;
		st_d = st_q;
		stamp_d = stamp_q;
		chg_d = 1'b0;
		take = 1'b0;
		st_age = st_q;
		case (cmd.typ)
			REQ_MERGE: begin
				if (cmd.node == idx && !is_self) begin
					take = cmd.force_req || !valid_q || (cmd.gen > gen_q) ||
						((cmd.gen == gen_q) && ((cmd.hb > hb_q) ||
						((cmd.hb == hb_q) && (cmd.st > st_q))));
					if (take) begin
						valid_d = 1'b1;
						gen_d = cmd.gen;
						hb_d = cmd.hb;
						st_d = cmd.st;
						stamp_d = cmd.clock_ms;
						chg_d = !valid_q || gen_q != cmd.gen || hb_q != cmd.hb ||
							st_q != cmd.st || stamp_q != cmd.clock_ms;
					end
				end
			end
			REQ_ROUND: begin
				if (is_self && valid_q) begin
					if (hb_q != HB_MAX) begin
						hb_d = hb_q + 32'd1;
						chg_d = 1'b1;
					end
					if (stamp_q != cmd.clock_ms) begin
						stamp_d = cmd.clock_ms;
						chg_d = 1'b1;
					end
				end else if (valid_q) begin
					if (st_age == ST_ALIVE && age > cmd.suspect_limit)
						st_age = ST_SUSPECT;
					if (st_age == ST_SUSPECT && age > cmd.dead_limit)
						st_age = ST_DEAD;
					st_d = st_age;
					chg_d = (st_age != st_q);
				end
			end
			REQ_DEPART: begin
				if (is_self && valid_q) begin
					st_d = ST_DEAD;
					chg_d = (st_q != ST_DEAD);
					if (hb_q != HB_MAX) begin
						hb_d = hb_q + 32'd1;
						chg_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Hold the record; reload own entry on a self write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= (idx == '0);
			gen_q <= (idx == '0) ? 32'd1 : 32'd0;
			hb_q <= '0;
			st_q <= ST_ALIVE;
			stamp_q <= '0;
			chg_q <= 1'b0;
		end else if (cmd.reload) begin
			if (idx == cmd.new_self) begin
				valid_q <= 1'b1;
				gen_q <= cmd.new_gen;
				hb_q <= '0;
				st_q <= ST_ALIVE;
				stamp_q <= cmd.clock_ms;
			end else if (idx == cmd.self_id) begin
				valid_q <= 1'b0;
				gen_q <= '0;
				hb_q <= '0;
				st_q <= ST_ALIVE;
				stamp_q <= '0;
			end
		end else if (cmd.en) begin
			valid_q <= valid_d;
			gen_q <= gen_d;
			hb_q <= hb_d;
			st_q <= st_d;
			stamp_q <= stamp_d;
			chg_q <= chg_d;
		end
	end

	// Pass the change flag along the chain
	assign chg_out = chg_in | chg_q;
	assign rec = '{valid: valid_q, gen: gen_q, hb: hb_q, st: st_q};
endmodule
`default_nettype wire
